@@ design/ivs_pkg.sv @@
// Shared types and constants for the indexed vector store.
// Request and result structs, function and status codes, sequencer states.
// No dependencies.
package ivs_pkg;

  // Store geometry
  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int ADDR_W        = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  // Fixed field widths of the transaction payloads
  localparam int FUNC_W = 3;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // Request function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH  = 3'd0,
    FN_POP   = 3'd1,
    FN_INS   = 3'd2,
    FN_ODEL  = 3'd3,
    FN_SDEL  = 3'd4,
    FN_SWAP  = 3'd5,
    FN_READ  = 3'd6
  } ivs_func_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } ivs_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RDOUT,
    S_SDWR,
    S_SW1,
    S_SW2,
    S_SW3,
    S_MOVE
  } ivs_state_t;

  // Input transaction
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [VAL_W-1:0]  value_in;
  } ivs_in_t;

  // Result transaction
  typedef struct packed {
    logic [VAL_W-1:0]  value_out;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
  } ivs_out_t;

  // Sequencer to memory request
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [ELEMENT_WIDTH-1:0] wdata;
    logic                     re;
    logic [ADDR_W-1:0]        raddr;
  } ivs_mem_req_t;

  // Sequencer completion report
  typedef struct packed {
    logic     done;
    ivs_out_t res;
  } ivs_fin_t;

endpackage

@@ design/ivs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ivs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ivs_seq.sv @@
// Request sequencer: checks each transaction against the live count and runs
// the read-modify-write steps on the element memory. Depends on ivs_pkg.
module ivs_seq
  import ivs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  ivs_in_t                  req,
  input  logic [ELEMENT_WIDTH-1:0] rdata,
  output logic                     busy,
  output ivs_mem_req_t             mem,
  output ivs_fin_t                 fin
);

  ivs_state_t               state_r, state_nxt;
  ivs_in_t                  req_r, req_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]        rp_r, rp_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic                     pend_r, pend_nxt;
  logic [ADDR_W-1:0]        pend_addr_r, pend_addr_nxt;
  logic [ELEMENT_WIDTH-1:0] tmp_r, tmp_nxt;
  ivs_status_t              chk;
  logic [CNT_W-1:0]         ia_ext, ib_ext;
  logic                     same_idx;
  logic                     is_ins;
  logic                     done;
  logic [VAL_W-1:0]         vout;
  ivs_status_t              st_out;

  assign busy     = (state_r != S_IDLE);
  assign ia_ext   = CNT_W'(req.index_a);
  assign ib_ext   = CNT_W'(req.index_b);
  assign same_idx = (req.index_a == req.index_b);
  assign is_ins   = (req_r.func == FN_INS);

  // Check an incoming request against the live count
  always_comb begin
    chk = ST_OK;
    case (req.func)
      FN_PUSH: begin
        if (cnt_r == CNT_W'(CAPACITY)) chk = ST_FULL;
      end
      FN_POP: begin
        if (cnt_r == '0) chk = ST_EMPTY;
      end
      FN_INS: begin
        if (cnt_r == '0)                     chk = ST_EMPTY;
        else if (ia_ext >= cnt_r)            chk = ST_RANGE;
        else if (cnt_r == CNT_W'(CAPACITY))  chk = ST_FULL;
      end
      FN_ODEL, FN_SDEL, FN_READ: begin
        if (cnt_r == '0)          chk = ST_EMPTY;
        else if (ia_ext >= cnt_r) chk = ST_RANGE;
      end
      FN_SWAP: begin
        if (same_idx)                                 chk = ST_OK;
        else if (cnt_r == '0)                         chk = ST_EMPTY;
        else if (ia_ext >= cnt_r || ib_ext >= cnt_r)  chk = ST_RANGE;
      end
      default: chk = ST_OK;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && chk == ST_OK) begin
          case (req.func)
            FN_POP, FN_READ: state_nxt = S_RDOUT;
            FN_SDEL:         state_nxt = S_SDWR;
            FN_SWAP:         state_nxt = same_idx ? S_IDLE : S_SW1;
            FN_INS, FN_ODEL: state_nxt = S_MOVE;
            default:         state_nxt = S_IDLE;
          endcase
        end
      end
      S_RDOUT: state_nxt = S_IDLE;
      S_SDWR:  state_nxt = S_IDLE;
      S_SW1:   state_nxt = S_SW2;
      S_SW2:   state_nxt = S_SW3;
      S_SW3:   state_nxt = S_IDLE;
      S_MOVE: begin
        if (rem_r == '0 && !pend_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory controls, datapath updates and completion
  always_comb begin
    mem           = '0;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    rp_nxt        = rp_r;
    rem_nxt       = rem_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    tmp_nxt       = tmp_r;
    done          = 1'b0;
    vout          = '0;
    st_out        = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          req_nxt = req;
          st_out  = chk;
          if (chk != ST_OK) begin
            done = 1'b1;
          end else begin
            case (req.func)
              FN_PUSH: begin
                mem.we    = 1'b1;
                mem.waddr = cnt_r[ADDR_W-1:0];
                mem.wdata = ELEMENT_WIDTH'(req.value_in);
                cnt_nxt   = cnt_r + CNT_W'(1);
                done      = 1'b1;
              end
              FN_POP, FN_SDEL: begin
                mem.re    = 1'b1;
                mem.raddr = ADDR_W'(cnt_r - CNT_W'(1));
              end
              FN_READ: begin
                mem.re    = 1'b1;
                mem.raddr = ADDR_W'(req.index_a);
              end
              FN_SWAP: begin
                if (same_idx) begin
                  done = 1'b1;
                end else begin
                  mem.re    = 1'b1;
                  mem.raddr = ADDR_W'(req.index_a);
                end
              end
              FN_INS: begin
                // Walk the tail from the top down
                rp_nxt  = ADDR_W'(cnt_r - CNT_W'(1));
                rem_nxt = cnt_r - ia_ext;
              end
              FN_ODEL: begin
                // Walk the tail from just above the hole upward
                rp_nxt  = ADDR_W'(ia_ext + CNT_W'(1));
                rem_nxt = cnt_r - ia_ext - CNT_W'(1);
              end
              default: done = 1'b1;
            endcase
          end
        end
      end
      S_RDOUT: begin
        vout = VAL_W'(rdata);
        if (req_r.func == FN_POP) cnt_nxt = cnt_r - CNT_W'(1);
        done = 1'b1;
      end
      S_SDWR: begin
        // Move the last element into the freed slot
        mem.we    = 1'b1;
        mem.waddr = ADDR_W'(req_r.index_a);
        mem.wdata = rdata;
        cnt_nxt   = cnt_r - CNT_W'(1);
        done      = 1'b1;
      end
      S_SW1: begin
        tmp_nxt   = rdata;
        mem.re    = 1'b1;
        mem.raddr = ADDR_W'(req_r.index_b);
      end
      S_SW2: begin
        mem.we    = 1'b1;
        mem.waddr = ADDR_W'(req_r.index_a);
        mem.wdata = rdata;
      end
      S_SW3: begin
        mem.we    = 1'b1;
        mem.waddr = ADDR_W'(req_r.index_b);
        mem.wdata = tmp_r;
        done      = 1'b1;
      end
      S_MOVE: begin
        // Write back the element read last cycle one place over
        if (pend_r) begin
          mem.we    = 1'b1;
          mem.waddr = is_ins ? pend_addr_r + ADDR_W'(1) : pend_addr_r - ADDR_W'(1);
          mem.wdata = rdata;
        end
        // Read the next element of the tail
        if (rem_r != '0) begin
          mem.re        = 1'b1;
          mem.raddr     = rp_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rp_r;
          rp_nxt        = is_ins ? rp_r - ADDR_W'(1) : rp_r + ADDR_W'(1);
          rem_nxt       = rem_r - CNT_W'(1);
        end else if (!pend_r) begin
          // Tail moved: drop the new element in, or shrink
          if (is_ins) begin
            mem.we    = 1'b1;
            mem.waddr = ADDR_W'(req_r.index_a);
            mem.wdata = ELEMENT_WIDTH'(req_r.value_in);
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          done = 1'b1;
        end
      end
      default: ;
    endcase
    fin.done          = done;
    fin.res.value_out = vout;
    fin.res.status    = st_out;
    fin.res.count     = cnt_nxt;
    fin.res.is_empty  = (cnt_nxt == '0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Datapath holding registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    rp_r        <= rp_nxt;
    rem_r       <= rem_nxt;
    pend_addr_r <= pend_addr_nxt;
    tmp_r       <= tmp_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("live count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem.we && mem.re && mem.waddr == mem.raddr))
    else $error("read and write to the same entry in one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fin.done |=> (state_r == S_IDLE))
    else $error("sequencer not idle after completing a transaction");

  a_move_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE && rem_r != '0) |=> pend_r)
    else $error("tail read issued without a pending write-back");
`endif

endmodule

@@ design/indexed_vector_store_core.sv @@
// Top level of the indexed vector store: element memory, sequencer and
// result register. Depends on ivs_pkg, ivs_ram and ivs_seq.
//
//   channel   handshake            payload
//   input     start / busy         in_req   (ivs_in_t)
//   result    out_strobe           out_res  (ivs_out_t)
//
// Push, no-op and rejected requests: result in the cycle after accept, busy stays low.
// Pop and read pass through S_RDOUT, swap delete through S_SDWR; swap of two slots steps through
// S_SW1, S_SW2 and S_SW3 (one memory read port). Insert and ordered delete walk the tail in S_MOVE,
// one element moved per cycle through the memory's read and write ports. Reset empties the store
// at once; no memory clearing pass. Results are never stalled.
module indexed_vector_store_core
  import ivs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ivs_in_t  in_req,
  output logic     out_strobe,
  output ivs_out_t out_res
);

  ivs_mem_req_t             mem;
  ivs_fin_t                 fin;
  logic [ELEMENT_WIDTH-1:0] rdata;
  logic                     acc;
  logic                     out_strobe_r;
  ivs_out_t                 out_res_r;

  assign acc = start && !busy;

  ivs_ram #(
    .WIDTH(ELEMENT_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem.we),
    .waddr(mem.waddr),
    .wdata(mem.wdata),
    .re   (mem.re),
    .raddr(mem.raddr),
    .rdata(rdata)
  );

  ivs_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (acc),
    .req  (in_req),
    .rdata(rdata),
    .busy (busy),
    .mem  (mem),
    .fin  (fin)
  );

  // Register each finished transaction onto the result ports with a one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= fin.done;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.done) begin
      out_res_r <= fin.res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule
